FILE: design/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;

  localparam int unsigned CFG_W = 4;

  // register indexes
  localparam logic [1:0] REG_SET_INDEX_BITS  = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS     = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE     = 2'd2;
  localparam logic [1:0] REG_PREFETCH_ENABLE = 2'd3;

  // access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] memory_reads;
    logic       memory_write;
  } out_item_t;

  typedef struct packed {
    logic [3:0] set_index_bits;
    logic [3:0] offset_bits;
    logic [3:0] ways_in_use;
    logic       prefetch_enable;
  } cfg_t;

  // result of one set update handed back to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } upd_status_t;

endpackage

FILE: design/salc_set_unit.sv
`timescale 1ns / 1ps
// One set row in memory: read, update recency order, write back.
module salc_set_unit #(
  parameter int SETS = 256,
  parameter int NWAYS = 8,
  parameter int TAGW = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req,        // start a lookup
  input  logic                     ins_only,   // prefetch: insert if absent, no recency move
  input  logic [$clog2(SETS)-1:0]  set_idx,
  input  logic [TAGW-1:0]          tag,
  input  logic [$clog2(NWAYS+1)-1:0] ways,
  output salc_pkg::upd_status_t    status
);
  import salc_pkg::*;

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int CW = $clog2(NWAYS + 1);
  localparam int PW = (NWAYS > 1) ? $clog2(NWAYS) : 1;

  typedef logic [NWAYS-1:0][TAGW-1:0] row_t;

  // tag rows, reset undefined
  row_t                tag_mem [SETS];
  logic [CW-1:0]       cnt_mem [SETS];
  // fill-count clear pass state
  logic [SW:0]         clr_r;
  logic                clr_busy;

  row_t                row_q;
  logic [CW-1:0]       cnt_q;
  logic                rd_r;
  logic                ins_r;
  logic [SW-1:0]       set_r;
  logic [TAGW-1:0]     tag_r;

  row_t                row_nxt;
  logic [CW-1:0]       cnt_nxt;
  logic [CW-1:0]       n_used;
  logic                found;
  logic [PW-1:0]       fpos;
  logic                we;

  assign clr_busy = !clr_r[SW];

  // clear pass over fill counts after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clr_busy) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // registered memory read; a write back to the same set in this cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_r && we && (set_r == set_idx[SW-1:0])) begin
      row_q <= row_nxt;
      cnt_q <= cnt_nxt;
    end else begin
      row_q <= tag_mem[set_idx[SW-1:0]];
      cnt_q <= cnt_mem[set_idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
    end else begin
      rd_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      ins_r <= ins_only;
      set_r <= set_idx[SW-1:0];
      tag_r <= tag;
    end
  end

  // search and reorder
  always_comb begin
    n_used = (cnt_q > ways) ? ways : cnt_q;
    found  = 1'b0;
    fpos   = '0;
    for (int p = 0; p < NWAYS; p++) begin
      if (!found && (p < n_used) && row_q[p] == tag_r) begin
        found = 1'b1;
        fpos  = PW'(p);
      end
    end
    row_nxt = row_q;
    cnt_nxt = cnt_q;
    we      = 1'b0;
    if (found) begin
      if (!ins_r) begin
        we = 1'b1;
        for (int p = 0; p < NWAYS; p++) begin
          if (p >= fpos && (p + 1) < n_used) row_nxt[p] = row_q[p+1];
          if ((p + 1) == n_used) row_nxt[p] = tag_r;
        end
      end
    end else begin
      we = 1'b1;
      if (n_used < ways) begin
        for (int p = 0; p < NWAYS; p++) begin
          if (p == n_used) row_nxt[p] = tag_r;
        end
        cnt_nxt = n_used + 1'b1;
      end else begin
        for (int p = 0; p < NWAYS; p++) begin
          if ((p + 1) < ways) row_nxt[p] = row_q[p+1];
          if ((p + 1) == ways) row_nxt[p] = tag_r;
        end
        cnt_nxt = ways;
      end
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (rd_r && we) begin
      tag_mem[set_r] <= row_nxt;
    end
    if (clr_busy) begin
      cnt_mem[clr_r[SW-1:0]] <= '0;
    end else if (rd_r && we) begin
      cnt_mem[set_r] <= cnt_nxt;
    end
  end

  assign status.done = rd_r;
  assign status.hit  = found;

  // fill count never exceeds the way count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r && we |-> cnt_nxt <= NWAYS)
    else $error("fill count out of range");
  a_done_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    req |=> rd_r)
    else $error("lookup lost");
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !rd_r)
    else $error("access during clear");
endmodule

FILE: design/set_assoc_lru_cache_prefetch.sv
`timescale 1ns / 1ps
// Set-associative LRU tag cache with next-block prefetch. Pulse start with
// in_item while busy is low; the result appears on out_item with out_valid
// high for exactly one cycle and is not held, so the receiver must take it
// then. The sequencer runs a demand lookup and, on a miss with prefetch
// enabled, a prefetch lookup before the result, as the set memory is read
// and written back once for the demand block and once more for the next
// block. Busy falls the cycle after the result, so a new transaction can be
// taken only after the previous result. After reset, busy stays high while
// the per-set fill counts are cleared. Configuration writes are taken at any
// time but should only be issued while busy is low.
module set_assoc_lru_cache_prefetch #(
  parameter int MAX_SETS  = 256,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  salc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output salc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);
  import salc_pkg::*;

  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DEM  = 3'd2;
  localparam logic [2:0] ST_PF   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  cfg_t              cfg_r;
  logic [2:0]        state_r;
  logic [SW:0]       clr_cnt_r;
  logic              mode_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic              hit_r;
  logic [1:0]        reads_r;

  logic              req;
  logic              ins_only;
  logic [ADDR_BITS-1:0] lk_addr;
  logic [SW-1:0]     lk_set;
  logic [ADDR_BITS-1:0] lk_tag;
  logic [ADDR_BITS-1:0] next_addr;
  logic [ADDR_BITS-1:0] raw;
  logic [CW-1:0]     ways_eff;
  upd_status_t       st;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{4'd0, 4'd1, 4'd1, 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_INDEX_BITS:  cfg_r.set_index_bits  <= cfg_data;
        REG_OFFSET_BITS:     cfg_r.offset_bits     <= cfg_data;
        REG_WAYS_IN_USE:     cfg_r.ways_in_use     <= cfg_data;
        REG_PREFETCH_ENABLE: cfg_r.prefetch_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_r.ways_in_use == 4'd0) ways_eff = CW'(1);
    else if (32'(cfg_r.ways_in_use) > WAYS) ways_eff = CW'(WAYS);
    else ways_eff = CW'(cfg_r.ways_in_use);
  end

  assign next_addr = addr_r + (ADDR_BITS'(1) << cfg_r.offset_bits);

  // split address into set and tag
  always_comb begin
    lk_addr = (state_r == ST_IDLE) ? ADDR_BITS'(in_item.address) : next_addr;
    raw     = (lk_addr >> cfg_r.offset_bits)
              & ((ADDR_BITS'(1) << cfg_r.set_index_bits) - 1'b1);
    lk_set  = raw[SW-1:0];
    if (MAX_SETS == 1) lk_set = '0;
    lk_tag  = lk_addr >> (5'(cfg_r.set_index_bits) + 5'(cfg_r.offset_bits));
    req      = 1'b0;
    ins_only = 1'b0;
    if (state_r == ST_IDLE && start) req = 1'b1;
    if (state_r == ST_DEM && st.done && !st.hit && cfg_r.prefetch_enable) begin
      req      = 1'b1;
      ins_only = 1'b1;
    end
  end

  salc_set_unit #(.SETS(MAX_SETS), .NWAYS(WAYS), .TAGW(ADDR_BITS)) u_set (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .ins_only(ins_only),
    .set_idx (lk_set),
    .tag     (lk_tag),
    .ways    (ways_eff),
    .status  (st)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r[SW]) state_r <= ST_IDLE;
        end
        ST_IDLE: if (start) state_r <= ST_DEM;
        ST_DEM: if (st.done) state_r <= req ? ST_PF : ST_DONE;
        ST_PF: if (st.done) state_r <= ST_DONE;
        ST_DONE: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      mode_r <= in_item.mode;
      addr_r <= ADDR_BITS'(in_item.address);
    end
    if (state_r == ST_DEM && st.done) begin
      hit_r   <= st.hit;
      reads_r <= st.hit ? 2'd0 : 2'd1;
    end
    if (state_r == ST_PF && st.done && !st.hit) begin
      reads_r <= 2'd2;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_item  = '{hit_r, reads_r, mode_r};

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("double result");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept not registered");
  a_reads_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> out_item.memory_reads == 2'd0)
    else $error("hit with fill");
endmodule

FILE: tb/set_assoc_lru_cache_prefetch_test.sv
`timescale 1ns / 1ps
module set_assoc_lru_cache_prefetch_test;
  import salc_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  set_assoc_lru_cache_prefetch DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the tag array, kept in recency order per set
  logic [31:0] shadow_tags [NSETS*NWAYS];
  int unsigned shadow_fill [NSETS];
  cfg_t shadow_cfg;

  in_item_t access_queue[$];
  out_item_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 0;

  function automatic int unsigned ways_eff();
    int unsigned w;
    w = shadow_cfg.ways_in_use;
    if (w == 0) w = 1;
    if (w > NWAYS) w = NWAYS;
    return w;
  endfunction

  function automatic void addr_split(input logic [31:0] a, output int unsigned s,
                                     output logic [31:0] t);
    logic [63:0] raw;
    raw = (64'(a) >> shadow_cfg.offset_bits) &
          ((64'd1 << shadow_cfg.set_index_bits) - 64'd1);
    s = int'(raw % NSETS);
    t = 32'(64'(a) >> (5'(shadow_cfg.set_index_bits) + 5'(shadow_cfg.offset_bits)));
  endfunction

  function automatic int tag_lookup(int unsigned s, logic [31:0] t, int unsigned n);
    for (int unsigned p = 0; p < n; p++)
      if (shadow_tags[s*NWAYS+p] == t) return p;
    return -1;
  endfunction

  function automatic void tag_fill(int unsigned s, logic [31:0] t, int unsigned w);
    int unsigned n;
    n = (shadow_fill[s] > w) ? w : shadow_fill[s];
    if (n < w) begin
      shadow_tags[s*NWAYS+n] = t;
      shadow_fill[s] = n + 1;
    end else begin
      for (int unsigned p = 0; p + 1 < w; p++)
        shadow_tags[s*NWAYS+p] = shadow_tags[s*NWAYS+p+1];
      shadow_tags[s*NWAYS+w-1] = t;
      shadow_fill[s] = w;
    end
  endfunction

  // work out the outcome of one access and update the shadow array
  function automatic out_item_t cache_access(in_item_t it);
    out_item_t r;
    int unsigned w, s, n;
    logic [31:0] t, nxt, held;
    int pos;
    w = ways_eff();
    r.hit = 1'b0;
    r.memory_reads = 2'd0;
    r.memory_write = it.mode;
    addr_split(it.address, s, t);
    n = (shadow_fill[s] > w) ? w : shadow_fill[s];
    pos = tag_lookup(s, t, n);
    if (pos >= 0) begin
      r.hit = 1'b1;
      held = shadow_tags[s*NWAYS+pos];
      for (int unsigned p = pos; p + 1 < n; p++)
        shadow_tags[s*NWAYS+p] = shadow_tags[s*NWAYS+p+1];
      shadow_tags[s*NWAYS+n-1] = held;
    end else begin
      tag_fill(s, t, w);
      r.memory_reads = 2'd1;
      if (shadow_cfg.prefetch_enable) begin
        nxt = it.address + (32'd1 << shadow_cfg.offset_bits);
        addr_split(nxt, s, t);
        n = (shadow_fill[s] > w) ? w : shadow_fill[s];
        if (tag_lookup(s, t, n) < 0) begin
          tag_fill(s, t, w);
          r.memory_reads = 2'd2;
        end
      end
    end
    return r;
  endfunction

  // driver: bursts with random gaps; start only rises while busy is low,
  // so each transaction is taken at the next rising edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (busy) begin
      start <= 1'b0;
    end else if (access_queue.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      in_item <= access_queue.pop_front();
      start <= 1'b1;
      if (burst_left <= 0) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor: predict on acceptance, check on strobe
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(cache_access(in_item));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.hit !== want.hit)
            $display("%0t: hit expected %b actual %b", $time, want.hit, out_item.hit);
          if (out_item.memory_reads !== want.memory_reads)
            $display("%0t: memory_reads expected %0d actual %0d", $time,
                     want.memory_reads, out_item.memory_reads);
          if (out_item.memory_write !== want.memory_write)
            $display("%0t: memory_write expected %b actual %b", $time,
                     want.memory_write, out_item.memory_write);
          if (out_item !== want) error_count++;
        end
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("set_assoc_lru_cache_prefetch_test failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SET_INDEX_BITS:  shadow_cfg.set_index_bits = val;
      REG_OFFSET_BITS:     shadow_cfg.offset_bits = val;
      REG_WAYS_IN_USE:     shadow_cfg.ways_in_use = val;
      default:             shadow_cfg.prefetch_enable = val[0];
    endcase
  endtask

  task automatic apply_setting(logic [3:0] sib, logic [3:0] ofs, logic [3:0] wy, logic pf);
    reg_write(REG_SET_INDEX_BITS, sib);
    reg_write(REG_OFFSET_BITS, ofs);
    reg_write(REG_WAYS_IN_USE, wy);
    reg_write(REG_PREFETCH_ENABLE, {3'b000, pf});
  endtask

  task automatic push_access(logic m, logic [31:0] a);
    in_item_t it;
    it.mode = m;
    it.address = a;
    access_queue.push_back(it);
  endtask

  // drain before touching the registers
  task automatic wait_idle();
    while (access_queue.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // mostly reuse a small pool of blocks so hits and evictions happen
  task automatic random_phase(int count);
    logic [31:0] pool [16];
    logic [31:0] a;
    for (int i = 0; i < 16; i++) pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    a = $urandom();
        2:       a = 32'hFFFF_FFFF - $urandom_range(0, 64);
        default: a = pool[$urandom_range(0, 15)] + $urandom_range(0, 4096);
      endcase
      push_access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_cfg.set_index_bits = 4'd0;
    shadow_cfg.offset_bits = 4'd1;
    shadow_cfg.ways_in_use = 4'd1;
    shadow_cfg.prefetch_enable = 1'b0;
    for (int s = 0; s < NSETS; s++) shadow_fill[s] = 0;
    for (int i = 0; i < NSETS*NWAYS; i++) shadow_tags[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, extremes of address, both modes
    push_access(MODE_READ, 32'h0);
    push_access(MODE_READ, 32'h0);
    push_access(MODE_WRITE, 32'h1);
    push_access(MODE_WRITE, 32'hFFFF_FFFF);
    push_access(MODE_READ, 32'hFFFF_FFFE);
    wait_idle();

    // ways of zero acts as one, offset of zero, prefetch wrapping past the top
    apply_setting(4'd0, 4'd0, 4'd0, 1'b1);
    push_access(MODE_READ, 32'hFFFF_FFFF);
    push_access(MODE_READ, 32'h0);
    push_access(MODE_WRITE, 32'hAAAA_5555);
    wait_idle();

    // ways above the limit, set index wider than the set count, max offset
    apply_setting(4'd15, 4'd15, 4'd15, 1'b1);
    push_access(MODE_READ, 32'h0000_8000);
    push_access(MODE_READ, 32'h0000_0000);
    push_access(MODE_READ, 32'h0000_8000);
    push_access(MODE_WRITE, 32'h5555_AAAA);
    wait_idle();

    // fewer ways with a full set: each new miss evicts the oldest block
    apply_setting(4'd0, 4'd4, 4'd2, 1'b0);
    push_access(MODE_READ, 32'h100);
    push_access(MODE_READ, 32'h200);
    push_access(MODE_READ, 32'h300);
    push_access(MODE_READ, 32'h100);
    wait_idle();

    // random phases over a spread of settings, no clear in between
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: apply_setting(4'd0, 4'd1, 4'd8, 1'b0);
        1: apply_setting(4'd8, 4'd12, 4'd8, 1'b1);
        2: apply_setting(4'd2, 4'd6, 4'd1, 1'b1);
        3: apply_setting(4'd1, 4'd1, 4'd4, 1'b1);
        default: apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      endcase
      random_phase(70);
      wait_idle();
    end

    stimulus_done = 1;
    if (error_count == 0) begin
      $display("set_assoc_lru_cache_prefetch_test passed");
    end else begin
      $display("set_assoc_lru_cache_prefetch_test failed");
    end
    $finish;
  end

endmodule
